// ----- src/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising clock edge outside reset
`define ASSERT_IMPLY(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

// ----- src/c2i_pkg.sv -----
package c2i_pkg;

   localparam int unsigned OPCODE_WIDTH = 2;
   localparam int unsigned STATUS_WIDTH = 2;
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH = 9;

   localparam logic [1:0] OP_PRELOAD = 2'd0;
   localparam logic [1:0] OP_ACCUMULATE = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   localparam logic [1:0] STATUS_DONE = 2'd0;
   localparam logic [1:0] STATUS_OUTSIDE = 2'd1;
   localparam logic [1:0] STATUS_BEYOND = 2'd2;

   localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd0;
   localparam logic [2:0] REG_IMAGE_WIDTH = 3'd1;
   localparam logic [2:0] REG_PAD_ROWS = 3'd2;
   localparam logic [2:0] REG_PAD_COLS = 3'd3;
   localparam logic [2:0] REG_STRIDE_ROWS = 3'd4;
   localparam logic [2:0] REG_STRIDE_COLS = 3'd5;
   localparam logic [2:0] REG_DILATION_ROWS = 3'd6;
   localparam logic [2:0] REG_DILATION_COLS = 3'd7;

   localparam logic [15:0] FP16_QNAN = 16'h7E00;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;     // capture the accepted item
      logic addr;     // register the image position, bounds check and plane size
      logic mem_rd;   // read the store word, register the word address and range check
      logic mem_wr;   // write the add or preload result
      logic result;   // capture the result item
   } ctrl_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic is_accumulate;
      logic is_preload;
      logic addr_ok;
   } stat_type;

   // ieee binary16 add, round to nearest even
   function automatic logic [15:0] fp16_add(input logic [15:0] a, input logic [15:0] b);
      logic a_nan, b_nan, a_inf, b_inf;
      logic [4:0] ea, eb, el;
      logic [13:0] ma, mb, big, lit;
      logic [4:0] d;
      logic [16:0] lw, bw;
      logic sticky, sbig, slit, ssum;
      logic [17:0] sum;
      logic [4:0] lz, ex;
      logic [17:0] norm;
      logic [10:0] keep;
      logic g, r, st;
      logic [11:0] rnd;
      logic [5:0] exn;
      logic [15:0] res;
      a_nan = (a[14:10] == 5'h1F) && (a[9:0] != 10'd0);
      b_nan = (b[14:10] == 5'h1F) && (b[9:0] != 10'd0);
      a_inf = (a[14:10] == 5'h1F) && !a_nan;
      b_inf = (b[14:10] == 5'h1F) && !b_nan;
      ea = (a[14:10] == 5'd0) ? 5'd1 : a[14:10];
      eb = (b[14:10] == 5'd0) ? 5'd1 : b[14:10];
      ma = {3'b000, a[14:10] != 5'd0, a[9:0]};
      mb = {3'b000, b[14:10] != 5'd0, b[9:0]};
      if ({ea, ma[10:0]} >= {eb, mb[10:0]}) begin
         big = ma; lit = mb; el = ea; d = ea - eb; sbig = a[15]; slit = b[15];
      end else begin
         big = mb; lit = ma; el = eb; d = eb - ea; sbig = b[15]; slit = a[15];
      end
      // three extra low bits: guard, round, sticky
      bw = {3'b000, big[10:0], 3'b000};
      lw = {3'b000, lit[10:0], 3'b000} >> ((d > 5'd16) ? 5'd16 : d);
      sticky = (d > 5'd13) ? (lit[10:0] != 11'd0)
                           : ((({3'b000, lit[10:0], 3'b000} << (5'd17 - d)) & 17'h1FFFF)
                              != 17'd0) && (d > 5'd3);
      lw[0] = lw[0] | sticky;
      ssum = sbig;
      if (sbig == slit) sum = {1'b0, bw} + {1'b0, lw};
      else sum = {1'b0, bw} - {1'b0, lw};
      // normalize: leading one to bit 13 when possible
      lz = 5'd0;
      for (int i = 0; i < 18; i++) begin
         if (sum[i]) lz = 5'(17 - i);
      end
      if (sum[14]) begin
         norm = sum >> 1; ex = el + 5'd1;
         norm[0] = norm[0] | sum[0];
      end else if (el > 5'(lz - 5'd4)) begin
         norm = sum << (lz - 5'd4); ex = el - (lz - 5'd4);
      end else begin
         norm = sum << (el - 5'd1); ex = 5'd0;
      end
      keep = norm[13:3];
      g = norm[2]; r = norm[1]; st = norm[0];
      rnd = {1'b0, keep} + {11'd0, g & (r | st | keep[0])};
      exn = {1'b0, ex};
      if (ex == 5'd0 && rnd[10]) exn = 6'd1;
      if (rnd[11]) begin
         exn = exn + 6'd1; rnd = rnd >> 1;
      end
      if (a_nan || b_nan) res = FP16_QNAN;
      else if (a_inf && b_inf) res = (a[15] ^ b[15]) ? FP16_QNAN : a;
      else if (a_inf) res = a;
      else if (b_inf) res = b;
      else if (sum == 18'd0) res = {a[15] & b[15], 15'd0};
      else if (exn >= 6'd31) res = {ssum, 15'h7C00};
      else res = {ssum, exn[4:0], rnd[9:0]};
      return res;
   endfunction

endpackage

// ----- src/c2i_if.sv -----
interface c2i_req_if;
   logic valid;
   logic ready;
   logic [1:0] opcode;
   logic [7:0] plane;
   logic [3:0] kernel_row;
   logic [3:0] kernel_col;
   logic [7:0] grid_row;
   logic [7:0] grid_col;
   logic [15:0] value;
   logic [11:0] word_address;
   modport source (output valid, opcode, plane, kernel_row, kernel_col, grid_row, grid_col,
                   value, word_address, input ready);
   modport sink (input valid, opcode, plane, kernel_row, kernel_col, grid_row, grid_col,
                 value, word_address, output ready);
endinterface

interface c2i_rsp_if;
   logic valid;
   logic ready;
   logic [15:0] read_value;
   logic [1:0] status;
   modport source (output valid, read_value, status, input ready);
   modport sink (input valid, read_value, status, output ready);
endinterface

interface c2i_csr_if;
   logic valid;
   logic ready;
   logic [2:0] index;
   logic [8:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- src/c2i_ctrl.sv -----
module c2i_ctrl
   import c2i_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output ctrl_type ctrl
);

   typedef enum logic [1:0] {IDLE, ADDR, MEM, WRITE} state_type;

   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   // next state; result held in an output register so the next item may start
   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff;
      ctrl = '0;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               ctrl.load = 1'b1;
               state_in = ADDR;
            end
         end
         ADDR: begin
            ctrl.addr = 1'b1;
            state_in = MEM;
         end
         MEM: begin
            ctrl.mem_rd = 1'b1;
            state_in = WRITE;
         end
         WRITE: begin
            if (!rsp_valid_in) begin
               ctrl.result = 1'b1;
               ctrl.mem_wr = stat.addr_ok && (stat.is_accumulate || stat.is_preload);
               rsp_valid_in = 1'b1;
               state_in = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- src/c2i_datapath.sv -----
module c2i_datapath
   import c2i_pkg::*;
#(
   parameter int unsigned IMAGE_WORDS = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic [2:0]  csr_index,
   input  logic [8:0]  csr_data,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_plane,
   input  logic [3:0]  req_kernel_row,
   input  logic [3:0]  req_kernel_col,
   input  logic [7:0]  req_grid_row,
   input  logic [7:0]  req_grid_col,
   input  logic [15:0] req_value,
   input  logic [11:0] req_word_address,
   input  ctrl_type    ctrl,
   output stat_type    stat,
   output logic [15:0] rsp_read_value,
   output logic [1:0]  rsp_status
);

   localparam int unsigned AW = (IMAGE_WORDS > 1) ? $clog2(IMAGE_WORDS) : 1;

   // configuration registers
   logic [8:0] height_ff, width_ff;
   logic [7:0] pad_r_ff, pad_c_ff;
   logic [4:0] str_r_ff, str_c_ff, dil_r_ff, dil_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= 9'd1; width_ff <= 9'd1;
         pad_r_ff <= '0; pad_c_ff <= '0;
         str_r_ff <= 5'd1; str_c_ff <= 5'd1; dil_r_ff <= 5'd1; dil_c_ff <= 5'd1;
      end else if (csr_valid) begin
         case (csr_index)
            REG_IMAGE_HEIGHT:  height_ff <= csr_data;
            REG_IMAGE_WIDTH:   width_ff <= csr_data;
            REG_PAD_ROWS:      pad_r_ff <= csr_data[7:0];
            REG_PAD_COLS:      pad_c_ff <= csr_data[7:0];
            REG_STRIDE_ROWS:   str_r_ff <= csr_data[4:0];
            REG_STRIDE_COLS:   str_c_ff <= csr_data[4:0];
            REG_DILATION_ROWS: dil_r_ff <= csr_data[4:0];
            REG_DILATION_COLS: dil_c_ff <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   // item capture with row and column products
   logic [1:0]  op_ff;
   logic [15:0] val_ff;
   logic [11:0] waddr_ff;
   logic [7:0]  plane_ff;
   logic [13:0] row_ff, col_ff;
   logic        outside_ff;

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         op_ff <= req_opcode;
         val_ff <= req_value;
         waddr_ff <= req_word_address;
         plane_ff <= req_plane;
         row_ff <= 14'(req_grid_row * str_r_ff) + 14'(req_kernel_row * dil_r_ff);
         col_ff <= 14'(req_grid_col * str_c_ff) + 14'(req_kernel_col * dil_c_ff);
      end
   end

   // image position, bounds and plane size
   logic signed [14:0] r_s, c_s;
   logic [17:0] plane_sz_ff;
   logic [8:0]  r_ff, c_ff;

   assign r_s = $signed({1'b0, row_ff}) - $signed({7'd0, pad_r_ff});
   assign c_s = $signed({1'b0, col_ff}) - $signed({7'd0, pad_c_ff});

   always_ff @(posedge clock) begin
      if (ctrl.addr) begin
         outside_ff <= (r_s < 0) || (r_s >= $signed({6'd0, height_ff}))
                    || (c_s < 0) || (c_s >= $signed({6'd0, width_ff}));
         plane_sz_ff <= 18'(height_ff * width_ff);
         r_ff <= r_s[8:0];
         c_ff <= c_s[8:0];
      end
   end

   // word address of the element, checked against the store size
   logic [25:0] wacc;
   logic [25:0] waddr_full;
   logic        addr_ok_ff;
   logic [AW-1:0] maddr_ff;

   assign wacc = 26'(plane_ff * plane_sz_ff) + 26'(r_ff * width_ff) + 26'(c_ff);
   assign waddr_full = (op_ff == OP_ACCUMULATE) ? wacc : 26'(waddr_ff);

   always_ff @(posedge clock) begin
      if (ctrl.mem_rd) begin
         addr_ok_ff <= (waddr_full < 26'(IMAGE_WORDS))
                       && !((op_ff == OP_ACCUMULATE) && outside_ff);
         maddr_ff <= AW'(waddr_full);
      end
   end

   // image store
   logic [15:0] mem [IMAGE_WORDS];
   logic [15:0] rdata_ff;
   logic [15:0] wdata;

   always_ff @(posedge clock) begin
      if (ctrl.mem_rd) rdata_ff <= mem[AW'(waddr_full)];
   end

   assign wdata = (op_ff == OP_PRELOAD) ? val_ff : fp16_add(rdata_ff, val_ff);

   always_ff @(posedge clock) begin
      if (ctrl.mem_wr) mem[maddr_ff] <= wdata;
   end

   // result register
   logic [15:0] rv_ff;
   logic [1:0]  st_ff;

   always_ff @(posedge clock) begin
      if (ctrl.result) begin
         rv_ff <= '0;
         st_ff <= STATUS_DONE;
         case (op_ff)
            OP_PRELOAD: if (!addr_ok_ff) st_ff <= STATUS_BEYOND;
            OP_READ: begin
               if (addr_ok_ff) rv_ff <= rdata_ff;
               else st_ff <= STATUS_BEYOND;
            end
            OP_ACCUMULATE: begin
               if (outside_ff) st_ff <= STATUS_OUTSIDE;
               else if (!addr_ok_ff) st_ff <= STATUS_BEYOND;
            end
            default: ;
         endcase
      end
   end

   assign stat.is_accumulate = (op_ff == OP_ACCUMULATE);
   assign stat.is_preload = (op_ff == OP_PRELOAD);
   assign stat.addr_ok = addr_ok_ff;
   assign rsp_read_value = rv_ff;
   assign rsp_status = st_ff;

endmodule

// ----- src/col2im_fp16_accumulate.sv -----
// col2im accumulate over an fp16 image store
// an accepted item passes the ADDR, MEM and WRITE states before its result is valid
// no new item is accepted until the previous one has finished its read-modify-write sequence
// a held result stalls only the final write step of the next item
// reset: synchronous, clears control and configuration; the store is not cleared
module col2im_fp16_accumulate
   import c2i_pkg::*;
#(
   parameter int unsigned IMAGE_WORDS = 4096
) (
   input  logic clock,
   input  logic reset,
   c2i_req_if.sink   req,
   c2i_rsp_if.source rsp,
   c2i_csr_if.sink   csr
);

   ctrl_type ctrl;
   stat_type stat;

   assign csr.ready = 1'b1;

   c2i_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .stat(stat), .ctrl(ctrl)
   );

   c2i_datapath #(.IMAGE_WORDS(IMAGE_WORDS)) u_dp (
      .clock(clock), .reset(reset),
      .csr_valid(csr.valid), .csr_index(csr.index), .csr_data(csr.data),
      .req_opcode(req.opcode), .req_plane(req.plane),
      .req_kernel_row(req.kernel_row), .req_kernel_col(req.kernel_col),
      .req_grid_row(req.grid_row), .req_grid_col(req.grid_col),
      .req_value(req.value), .req_word_address(req.word_address),
      .ctrl(ctrl), .stat(stat),
      .rsp_read_value(rsp.read_value), .rsp_status(rsp.status)
   );

endmodule

// ----- src/c2i_checker.sv -----
`include "assert_macros.svh"

module c2i_checker
   import c2i_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_read_value,
   input logic [1:0]  rsp_status
);

   `ASSERT_IMPLY(a_status_code, clock, reset, rsp_valid, rsp_status != 2'd3, "bad status")
   `ASSERT_IMPLY(a_value_zero, clock, reset, rsp_valid && rsp_status != STATUS_DONE, rsp_read_value == 16'd0, "value on error")
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "ready after accept")
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status), "result dropped")

endmodule

bind col2im_fp16_accumulate c2i_checker u_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_read_value(rsp.read_value), .rsp_status(rsp.status)
);

// ----- verif/col2im_scoreboard.sv -----
// watches the three channels, predicts each result and compares it
module col2im_scoreboard
   import c2i_pkg::*;
(
   input  logic clock,
   input  logic reset,
   c2i_req_if   req,
   c2i_rsp_if   rsp,
   c2i_csr_if   csr,
   output int   errors,
   output int   pending,
   output int   added,
   output int   skipped,
   output int   beyond,
   output int   reads
);

   localparam int STORE_WORDS = 4096;

   typedef struct {
      logic [15:0] read_value;
      logic [1:0]  status;
   } result_t;

   result_t     expected_results[$];
   logic [15:0] image_words [STORE_WORDS];
   int unsigned height, width, pad_r, pad_c, step_r, step_c, tap_r, tap_c;

   // magnitude of an fp16 pattern in units of 2^-24
   function automatic longint unsigned half_mag(input logic [15:0] h);
      longint unsigned m;
      m = h[9:0];
      if (h[14:10] == 5'd0) return m;
      return (m | 64'h400) << (h[14:10] - 1);
   endfunction

   // exact sum then one rounding to nearest even
   function automatic logic [15:0] half_sum(input logic [15:0] a, input logic [15:0] b);
      logic a_nan, b_nan, a_inf, b_inf;
      longint sa, sb, total;
      longint unsigned mag, keep, rem, half;
      int p, s;
      logic [15:0] sign;
      a_nan = (a[14:10] == 5'h1F) && (a[9:0] != 0);
      b_nan = (b[14:10] == 5'h1F) && (b[9:0] != 0);
      a_inf = (a[14:10] == 5'h1F) && !a_nan;
      b_inf = (b[14:10] == 5'h1F) && !b_nan;
      if (a_nan || b_nan) return FP16_QNAN;
      if (a_inf && b_inf) return (a[15] != b[15]) ? FP16_QNAN : a;
      if (a_inf) return a;
      if (b_inf) return b;
      sa = longint'(half_mag(a));
      sb = longint'(half_mag(b));
      if (a[15]) sa = -sa;
      if (b[15]) sb = -sb;
      total = sa + sb;
      if (total == 0) return {a[15] & b[15], 15'd0};
      sign = (total < 0) ? 16'h8000 : 16'h0000;
      mag = longint'(total < 0 ? -total : total);
      if (mag < 2048) return sign | 16'(mag);
      p = 0;
      while ((mag >> (p + 1)) != 0) p++;
      s = p - 10;
      keep = mag >> s;
      rem = mag & ((64'd1 << s) - 1);
      half = 64'd1 << (s - 1);
      if (rem > half || (rem == half && keep[0])) keep++;
      if (keep == 2048) begin
         keep = 1024;
         s++;
      end
      if (s + 1 >= 31) return sign | 16'h7C00;
      return sign | 16'((s + 1) << 10) | 16'(keep - 1024);
   endfunction

   // prediction for one accepted item
   function automatic result_t predict_item();
      result_t res;
      longint r, c, w;
      res.read_value = 16'd0;
      res.status = STATUS_DONE;
      case (req.opcode)
         OP_PRELOAD: image_words[req.word_address] = req.value;
         OP_READ: begin
            res.read_value = image_words[req.word_address];
            reads++;
         end
         OP_ACCUMULATE: begin
            r = longint'(req.grid_row) * step_r + longint'(req.kernel_row) * tap_r - pad_r;
            c = longint'(req.grid_col) * step_c + longint'(req.kernel_col) * tap_c - pad_c;
            if (r < 0 || r >= height || c < 0 || c >= width) begin
               res.status = STATUS_OUTSIDE;
               skipped++;
            end else begin
               w = longint'(req.plane) * height * width + r * width + c;
               if (w < STORE_WORDS) begin
                  image_words[w] = half_sum(image_words[w], req.value);
                  added++;
               end else begin
                  res.status = STATUS_BEYOND;
                  beyond++;
               end
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   initial begin
      errors = 0; added = 0; skipped = 0; beyond = 0; reads = 0;
      foreach (image_words[i]) image_words[i] = 16'd0;
   end

   always @(posedge clock) begin
      result_t want;
      if (reset) begin
         height = 1; width = 1; pad_r = 0; pad_c = 0;
         step_r = 1; step_c = 1; tap_r = 1; tap_c = 1;
         expected_results.delete();
      end else begin
         // register writes
         if (csr.valid && csr.ready) begin
            case (csr.index)
               REG_IMAGE_HEIGHT:  height = csr.data;
               REG_IMAGE_WIDTH:   width = csr.data;
               REG_PAD_ROWS:      pad_r = csr.data[7:0];
               REG_PAD_COLS:      pad_c = csr.data[7:0];
               REG_STRIDE_ROWS:   step_r = csr.data[4:0];
               REG_STRIDE_COLS:   step_c = csr.data[4:0];
               REG_DILATION_ROWS: tap_r = csr.data[4:0];
               REG_DILATION_COLS: tap_c = csr.data[4:0];
               default: ;
            endcase
         end
         // compare the result item before queuing new ones
         if (rsp.valid && rsp.ready) begin
            if (expected_results.size() == 0) begin
               $error("result item with nothing expected: read_value %h status %0d",
                      rsp.read_value, rsp.status);
               errors++;
            end else begin
               want = expected_results.pop_front();
               if (rsp.read_value !== want.read_value) begin
                  $error("read_value expected %h actual %h", want.read_value, rsp.read_value);
                  errors++;
               end
               if (rsp.status !== want.status) begin
                  $error("status expected %0d actual %0d", want.status, rsp.status);
                  errors++;
               end
            end
         end
         if (req.valid && req.ready) expected_results.push_back(predict_item());
      end
      pending <= expected_results.size();
   end

endmodule

// ----- verif/col2im_fp16_accumulate_tb.sv -----
module col2im_fp16_accumulate_tb;
   import c2i_pkg::*;

   localparam int STORE_WORDS = 4096;
   localparam int CYCLE_LIMIT = 600000;

   typedef struct {
      logic [1:0]  opcode;
      logic [7:0]  plane;
      logic [3:0]  kernel_row;
      logic [3:0]  kernel_col;
      logic [7:0]  grid_row;
      logic [7:0]  grid_col;
      logic [15:0] value;
      logic [11:0] word_address;
   } item_t;

   logic clock;
   logic reset;
   int   cycles;
   int   errors, pending, added, skipped, beyond, reads;
   bit   idle_on;
   bit   hold_rsp;
   bit   written [STORE_WORDS];
   int   written_list[$];
   int   cfg [8];
   int   sent;

   c2i_req_if req ();
   c2i_rsp_if rsp ();
   c2i_csr_if csr ();

   col2im_fp16_accumulate #(.IMAGE_WORDS(STORE_WORDS)) uut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp), .csr(csr)
   );

   col2im_scoreboard scoreboard (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp), .csr(csr),
      .errors(errors), .pending(pending), .added(added), .skipped(skipped),
      .beyond(beyond), .reads(reads)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // result side: random stalls, plus one long hold on request
   initial begin
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp.ready <= 1'b0;
            hold_rsp <= 1'b0;
            repeat (300) @(posedge clock);
         end else if (idle_on && $urandom_range(0, 6) == 0) begin
            rsp.ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   // offer one item and wait for it to be taken
   task automatic offer(input item_t it);
      req.valid <= 1'b1;
      req.opcode <= it.opcode;
      req.plane <= it.plane;
      req.kernel_row <= it.kernel_row;
      req.kernel_col <= it.kernel_col;
      req.grid_row <= it.grid_row;
      req.grid_col <= it.grid_col;
      req.value <= it.value;
      req.word_address <= it.word_address;
      do @(posedge clock); while (!req.ready);
      sent++;
      if (it.opcode == OP_PRELOAD && !written[it.word_address]) begin
         written[it.word_address] = 1'b1;
         written_list.push_back(it.word_address);
      end
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] index, input int data);
      csr.valid <= 1'b1;
      csr.index <= index;
      csr.data <= 9'(data);
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 1'b0;
      cfg[index] = data;
      @(posedge clock);
   endtask

   function automatic item_t make_item(input logic [1:0] op, input int plane, input int kr,
                                       input int kc, input int gr, input int gc,
                                       input logic [15:0] val, input int addr);
      item_t it;
      it.opcode = op; it.plane = 8'(plane);
      it.kernel_row = 4'(kr); it.kernel_col = 4'(kc);
      it.grid_row = 8'(gr); it.grid_col = 8'(gc);
      it.value = val; it.word_address = 12'(addr);
      return it;
   endfunction

   // store word an accumulate item lands on, -1 when outside the image
   function automatic longint landing_word(input item_t it);
      longint r, c;
      r = longint'(it.grid_row) * cfg[REG_STRIDE_ROWS]
          + longint'(it.kernel_row) * cfg[REG_DILATION_ROWS] - cfg[REG_PAD_ROWS];
      c = longint'(it.grid_col) * cfg[REG_STRIDE_COLS]
          + longint'(it.kernel_col) * cfg[REG_DILATION_COLS] - cfg[REG_PAD_COLS];
      if (r < 0 || r >= cfg[REG_IMAGE_HEIGHT] || c < 0 || c >= cfg[REG_IMAGE_WIDTH])
         return -1;
      return longint'(it.plane) * cfg[REG_IMAGE_HEIGHT] * cfg[REG_IMAGE_WIDTH]
             + r * cfg[REG_IMAGE_WIDTH] + c;
   endfunction

   function automatic logic [15:0] random_half();
      logic [15:0] specials [10] = '{16'h0000, 16'h8000, 16'h7C00, 16'hFC00, 16'h7BFF,
                                     16'hFBFF, 16'h0001, 16'h03FF, 16'h7E00, 16'h3C00};
      if ($urandom_range(0, 3) == 0) return specials[$urandom_range(0, 9)];
      return 16'($urandom);
   endfunction

   // accumulate, preloading the landing word first if it was never written
   task automatic accumulate_safely(input item_t it);
      longint w;
      w = landing_word(it);
      if (w >= 0 && w < STORE_WORDS && !written[w])
         offer(make_item(OP_PRELOAD, 0, 0, 0, 0, 0, random_half(), int'(w)));
      offer(it);
   endtask

   task automatic random_item();
      item_t it;
      int pick;
      pick = $urandom_range(0, 99);
      it = make_item(OP_ACCUMULATE, $urandom_range(0, 3), $urandom_range(0, 3),
                     $urandom_range(0, 3), $urandom_range(0, 7), $urandom_range(0, 7),
                     random_half(), 0);
      if (pick < 45) begin
         accumulate_safely(it);
      end else if (pick < 55) begin
         it.plane = 8'($urandom); it.kernel_row = 4'($urandom); it.kernel_col = 4'($urandom);
         it.grid_row = 8'($urandom); it.grid_col = 8'($urandom);
         it.word_address = 12'($urandom);
         accumulate_safely(it);
      end else if (pick < 75) begin
         it.opcode = OP_PRELOAD;
         it.word_address = ($urandom_range(0, 3) == 0) ? 12'($urandom)
                                                         : 12'($urandom_range(0, 1023));
         offer(it);
      end else if (pick < 95) begin
         if (written_list.size() == 0) offer(make_item(OP_PRELOAD, 0, 0, 0, 0, 0, 16'h0, 0));
         it.opcode = OP_READ;
         it.word_address = 12'(written_list[$urandom_range(0, written_list.size() - 1)]);
         offer(it);
      end else begin
         it.opcode = 2'd3;
         it.word_address = 12'($urandom);
         offer(it);
      end
   endtask

   // register settings per phase: height, width, pads, strides, dilations
   int phases [7][8] = '{
      '{8, 8, 1, 1, 1, 1, 1, 1},
      '{16, 12, 2, 0, 2, 1, 1, 2},
      '{256, 256, 255, 255, 16, 16, 16, 16},
      '{0, 5, 0, 0, 0, 0, 0, 0},
      '{511, 511, 0, 0, 31, 31, 31, 31},
      '{4, 4, 0, 3, 1, 3, 2, 1},
      '{8, 8, 1, 1, 1, 1, 1, 1}
   };

   initial begin
      reset = 1'b1;
      idle_on = 1'b1;
      hold_rsp = 1'b0;
      sent = 0;
      req.valid = 1'b0;
      req.opcode = OP_PRELOAD; req.plane = 0; req.kernel_row = 0; req.kernel_col = 0;
      req.grid_row = 0; req.grid_col = 0; req.value = 0; req.word_address = 0;
      csr.valid = 1'b0; csr.index = REG_IMAGE_HEIGHT; csr.data = 0;
      foreach (written[i]) written[i] = 1'b0;
      cfg = '{1, 1, 0, 0, 1, 1, 1, 1};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed items on the reset setting, where the word is the plane
      offer(make_item(OP_PRELOAD, 0, 0, 0, 0, 0, 16'h7C00, 0));
      offer(make_item(OP_ACCUMULATE, 0, 0, 0, 0, 0, 16'hFC00, 0));  // inf minus inf
      offer(make_item(OP_READ, 0, 0, 0, 0, 0, 16'h0, 0));
      offer(make_item(OP_PRELOAD, 0, 0, 0, 0, 0, 16'h7BFF, 0));
      offer(make_item(OP_ACCUMULATE, 0, 0, 0, 0, 0, 16'h7BFF, 0));  // overflow
      offer(make_item(OP_PRELOAD, 0, 0, 0, 0, 0, 16'h8000, 1));
      offer(make_item(OP_ACCUMULATE, 1, 0, 0, 0, 0, 16'h8000, 0));  // negative zeros
      offer(make_item(OP_PRELOAD, 0, 0, 0, 0, 0, 16'h3C00, 2));
      offer(make_item(OP_ACCUMULATE, 2, 0, 0, 0, 0, 16'hBC00, 0));  // exact cancel
      offer(make_item(OP_PRELOAD, 0, 0, 0, 0, 0, 16'h0001, 3));
      offer(make_item(OP_ACCUMULATE, 3, 0, 0, 0, 0, 16'h03FF, 0));  // subnormal carry
      offer(make_item(OP_PRELOAD, 0, 0, 0, 0, 0, 16'hFFFF, 255));
      offer(make_item(OP_ACCUMULATE, 255, 0, 0, 0, 0, 16'h7E01, 0)); // nan operand
      offer(make_item(OP_ACCUMULATE, 0, 15, 15, 255, 255, 16'hFFFF, 4095)); // outside
      offer(make_item(2'd3, 255, 15, 15, 255, 255, 16'hFFFF, 4095));
      offer(make_item(OP_PRELOAD, 0, 0, 0, 0, 0, 16'h5555, 4095));
      offer(make_item(OP_READ, 0, 0, 0, 0, 0, 16'h0, 4095));
      for (int w = 1; w < 4; w++) offer(make_item(OP_READ, 0, 0, 0, 0, 0, 16'h0, w));
      offer(make_item(OP_READ, 0, 0, 0, 0, 0, 16'h0, 255));
      drain();

      // random phases, one register setting each
      for (int ph = 0; ph < 7; ph++) begin
         for (int k = 0; k < 8; k++) write_reg(3'(k), phases[ph][k]);
         if (ph == 6) idle_on = 1'b0;
         for (int n = 0; n < 105; n++) begin
            // block fills while results are held back
            if (ph == 1 && n == 20) hold_rsp <= 1'b1;
            if (ph == 2 && n == 50) drain();
            random_item();
         end
         drain();
      end

      $display("sent %0d items: %0d accumulated, %0d outside the image, %0d beyond the store,",
               sent, added, skipped, beyond);
      $display("%0d reads, over 8 register settings incl. zero and all-ones sizes", reads);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+src
src/c2i_pkg.sv
src/c2i_if.sv
src/c2i_ctrl.sv
src/c2i_datapath.sv
src/col2im_fp16_accumulate.sv
src/c2i_checker.sv
verif/col2im_scoreboard.sv
verif/col2im_fp16_accumulate_tb.sv
